FILE: design/brpc_pkg.sv
// Shared types and codes for the bistable relay pulse controller.
// Used by brpc_csr, the top level and the port checker.
package brpc_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_TOGGLE_MODE      = 3'd0,
      CSR_ACTIVE_HIGH      = 3'd1,
      CSR_RESET_AT_STARTUP = 3'd2,
      CSR_PAUSE_TENTHS     = 3'd3,
      CSR_PULSE_TENTHS     = 3'd4,
      CSR_ON_SECONDS       = 3'd5,
      CSR_DEBOUNCE_ENABLE  = 3'd6,
      CSR_DEBOUNCE_TICKS   = 3'd7
   } csr_index_type;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 8;

   // Reset values of the configuration registers
   localparam logic [7:0] PAUSE_TENTHS_RESET   = 8'd5;
   localparam logic [7:0] PULSE_TENTHS_RESET   = 8'd2;
   localparam logic [7:0] DEBOUNCE_TICKS_RESET = 8'd15;

   // Pending relay request
   typedef enum logic [1:0] {
      REQ_NONE   = 2'd0,
      REQ_SWITCH = 2'd1,
      REQ_RESET  = 2'd2
   } request_type;

   // Coil drive state
   typedef enum logic [1:0] {
      COIL_OFF   = 2'd0,
      COIL_RESET = 2'd1,
      COIL_SET   = 2'd2
   } coil_type;

   // Last active level taken by a debounce recheck
   typedef enum logic [1:0] {
      ACC_LOW     = 2'd0,
      ACC_HIGH    = 2'd1,
      ACC_UNKNOWN = 2'd2
   } accepted_type;

   // Configuration seen by the step logic
   typedef struct packed {
      logic       toggle_mode;
      logic       active_high;
      logic       reset_at_startup;
      logic [7:0] pause_tenths;
      logic [7:0] pulse_tenths;
      logic [7:0] on_seconds;
      logic       debounce_enable;
      logic [7:0] debounce_ticks;
   } cfg_type;

   // Result word bit positions
   localparam int RSP_COIL_RESET = 0;
   localparam int RSP_COIL_SET   = 1;
   localparam int RSP_RELAY_LED  = 2;
   localparam int RSP_INFO_LED   = 3;

endpackage

FILE: design/brpc_csr.sv
// Configuration register file of the relay controller.
// Depends on brpc_pkg for the register indexes and cfg_type.
module brpc_csr
   import brpc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into one register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TOGGLE_MODE:      cfg_in.toggle_mode      = csr_wdata[0];
            CSR_ACTIVE_HIGH:      cfg_in.active_high      = csr_wdata[0];
            CSR_RESET_AT_STARTUP: cfg_in.reset_at_startup = csr_wdata[0];
            CSR_PAUSE_TENTHS:     cfg_in.pause_tenths     = csr_wdata;
            CSR_PULSE_TENTHS:     cfg_in.pulse_tenths     = csr_wdata;
            CSR_ON_SECONDS:       cfg_in.on_seconds       = csr_wdata;
            CSR_DEBOUNCE_ENABLE:  cfg_in.debounce_enable  = csr_wdata[0];
            CSR_DEBOUNCE_TICKS:   cfg_in.debounce_ticks   = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.toggle_mode      <= 1'b0;
         cfg_ff.active_high      <= 1'b1;
         cfg_ff.reset_at_startup <= 1'b0;
         cfg_ff.pause_tenths     <= PAUSE_TENTHS_RESET;
         cfg_ff.pulse_tenths     <= PULSE_TENTHS_RESET;
         cfg_ff.on_seconds       <= 8'd0;
         cfg_ff.debounce_enable  <= 1'b1;
         cfg_ff.debounce_ticks   <= DEBOUNCE_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/bistable_relay_pulse_controller.sv
// The result word of a tick word is registered in the result register at the edge that accepts the tick word.
// Throughput: one tick word per cycle while results are taken; the result register frees itself in the
// cycle the result is taken, so input and output run back to back.
// Reset (synchronous, active high) clears all controller state and the
// configuration to its defaults; no clearing pass is needed.
// Depends on brpc_pkg and brpc_csr.
module bistable_relay_pulse_controller
   import brpc_pkg::*;
#(
   parameter int TICKS_PER_TENTH   = 10,
   parameter int TENTHS_PER_SECOND = 10,
   parameter int COUNT_WIDTH       = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // Input words
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [0] raw_level, rest zero
   // Result words
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [0] coil_reset_drive,
                                                   // [1] coil_set_drive,
                                                   // [2] relay_led, [3] info_led
   // Configuration
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int TICK_W  = $clog2(TICKS_PER_TENTH + 1);
   localparam int TENTH_W = $clog2(TENTHS_PER_SECOND + 1);

   cfg_type cfg;

   brpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Controller state
   logic                   relay_ff,     relay_in;
   request_type            pend_ff,      pend_in;
   logic                   started_ff,   started_in;
   logic                   prev_raw_ff,  prev_raw_in;
   logic                   deb_busy_ff,  deb_busy_in;
   logic [7:0]             deb_left_ff,  deb_left_in;
   accepted_type           last_acc_ff,  last_acc_in;
   logic [COUNT_WIDTH-1:0] pause_ff,     pause_in;
   logic [COUNT_WIDTH-1:0] pulse_ff,     pulse_in;
   logic [COUNT_WIDTH-1:0] on_left_ff,   on_left_in;
   logic [TICK_W-1:0]      tick_ff,      tick_in;
   logic [TENTH_W-1:0]     tenth_ff,     tenth_in;
   coil_type               coil_ff,      coil_in;
   logic                   info_ff,      info_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_data_ff,  rsp_data_in;

   logic                   accept;
   logic                   raw;
   logic                   active;
   accepted_type           active_code;
   logic [TICK_W-1:0]      tick_next;
   logic [TENTH_W-1:0]     tenth_next;
   logic                   finish;
   logic                   take;
   logic                   do_sw;
   logic                   sw_set;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign raw        = req_tdata[0];
   assign active     = (raw == cfg.active_high);
   assign active_code = active ? ACC_HIGH : ACC_LOW;
   assign tick_next  = tick_ff + TICK_W'(1);
   assign tenth_next = tenth_ff + TENTH_W'(1);

   // Step logic for one tick: start-up rule or edge, tenth timer, request handling
   always_comb begin
      relay_in    = relay_ff;
      pend_in     = pend_ff;
      started_in  = started_ff;
      prev_raw_in = raw;
      deb_busy_in = deb_busy_ff;
      deb_left_in = deb_left_ff;
      last_acc_in = last_acc_ff;
      pause_in    = pause_ff;
      pulse_in    = pulse_ff;
      on_left_in  = on_left_ff;
      tick_in     = tick_next;
      tenth_in    = tenth_ff;
      coil_in     = coil_ff;
      info_in     = info_ff;
      finish      = 1'b0;
      take        = 1'b0;
      do_sw       = 1'b0;
      sw_set      = 1'b0;

      // Start-up rule on the first tick, edge detection afterwards
      if (!started_ff) begin
         started_in = 1'b1;
         if (cfg.toggle_mode) begin
            if (cfg.reset_at_startup) pend_in = REQ_RESET;
         end else if (active) begin
            pend_in = REQ_SWITCH;
         end else if (cfg.reset_at_startup) begin
            pend_in = REQ_RESET;
         end
      end else if (raw != prev_raw_ff && pause_ff == '0) begin
         pend_in = REQ_SWITCH;
      end

      // Tenth timer
      if (tick_next >= TICK_W'(TICKS_PER_TENTH)) begin
         tick_in = '0;
         tenth_in = tenth_next;
         if (tenth_next >= TENTH_W'(TENTHS_PER_SECOND)) begin
            tenth_in = '0;
            if (on_left_ff != '0) begin
               on_left_in = on_left_ff - COUNT_WIDTH'(1);
               if (on_left_in == '0) pend_in = REQ_RESET;
            end
         end
         if (pause_ff != '0) begin
            pause_in = pause_ff - COUNT_WIDTH'(1);
            if (pause_in == '0 && !cfg.toggle_mode && active != relay_ff
                && pulse_ff == '0) begin
               pend_in = REQ_SWITCH;
            end
         end
         if (pulse_ff != '0) begin
            pulse_in = pulse_ff - COUNT_WIDTH'(1);
            if (pulse_in == '0) begin
               coil_in = COIL_OFF;
               info_in = 1'b0;
            end
         end
      end

      // Request handling
      if (deb_busy_ff) begin
         if (deb_left_ff != 8'd0) deb_left_in = deb_left_ff - 8'd1;
         if (deb_left_in == 8'd0) finish = 1'b1;
      end else if (pend_in == REQ_RESET) begin
         do_sw = 1'b1;
      end else if (pend_in == REQ_SWITCH) begin
         if (cfg.debounce_enable) begin
            deb_busy_in = 1'b1;
            deb_left_in = cfg.debounce_ticks;
            if (cfg.debounce_ticks == 8'd0) finish = 1'b1;
         end else begin
            take = 1'b1;
         end
      end

      // Recheck after the debounce wait: drop if the level is unchanged
      if (finish) begin
         deb_busy_in = 1'b0;
         if (active_code == last_acc_ff) begin
            pend_in = REQ_NONE;
         end else begin
            last_acc_in = active_code;
            take = 1'b1;
         end
      end

      if (take) begin
         do_sw  = 1'b1;
         sw_set = cfg.toggle_mode ? !relay_ff : active;
      end

      // Drive a coil pulse and restart the timers
      if (do_sw) begin
         relay_in = sw_set;
         coil_in  = sw_set ? COIL_SET : COIL_RESET;
         info_in  = 1'b1;
         if (sw_set) on_left_in = COUNT_WIDTH'(cfg.on_seconds);
         pulse_in = COUNT_WIDTH'(cfg.pulse_tenths);
         pause_in = COUNT_WIDTH'(cfg.pause_tenths);
         tick_in  = '0;
         pend_in  = REQ_NONE;
      end
   end

   // Result word and output register handshake
   always_comb begin
      rsp_data_in = 8'd0;
      rsp_data_in[RSP_COIL_RESET] = (coil_in == COIL_RESET);
      rsp_data_in[RSP_COIL_SET]   = (coil_in == COIL_SET);
      rsp_data_in[RSP_RELAY_LED]  = relay_in;
      rsp_data_in[RSP_INFO_LED]   = info_in;
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   end

   // Advance the controller state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff    <= 1'b0;
         pend_ff     <= REQ_NONE;
         started_ff  <= 1'b0;
         prev_raw_ff <= 1'b0;
         deb_busy_ff <= 1'b0;
         deb_left_ff <= 8'd0;
         last_acc_ff <= ACC_UNKNOWN;
         pause_ff    <= '0;
         pulse_ff    <= '0;
         on_left_ff  <= '0;
         tick_ff     <= '0;
         tenth_ff    <= '0;
         coil_ff     <= COIL_OFF;
         info_ff     <= 1'b0;
      end else if (accept) begin
         relay_ff    <= relay_in;
         pend_ff     <= pend_in;
         started_ff  <= started_in;
         prev_raw_ff <= prev_raw_in;
         deb_busy_ff <= deb_busy_in;
         deb_left_ff <= deb_left_in;
         last_acc_ff <= last_acc_in;
         pause_ff    <= pause_in;
         pulse_ff    <= pulse_in;
         on_left_ff  <= on_left_in;
         tick_ff     <= tick_in;
         tenth_ff    <= tenth_in;
         coil_ff     <= coil_in;
         info_ff     <= info_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: design/brpc_check.sv
// Port-level checker for the relay controller, bound to the top level.
// Depends on brpc_pkg for the result bit positions.
module brpc_check
   import brpc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // Never drive both coil directions
   a_one_coil: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[RSP_COIL_RESET] && rsp_tdata[RSP_COIL_SET]))
      else $error("both coil drives active");

   // Info LED lights exactly while a coil is driven
   a_info_tracks_coil: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_INFO_LED] ==
                      (rsp_tdata[RSP_COIL_RESET] || rsp_tdata[RSP_COIL_SET])))
      else $error("info LED out of step with coil drive");

   // A set pulse shows the relay set, a reset pulse shows it reset
   a_coil_matches_relay: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[RSP_COIL_SET] || rsp_tdata[RSP_COIL_RESET])
      |-> (rsp_tdata[RSP_RELAY_LED] == rsp_tdata[RSP_COIL_SET]))
      else $error("coil direction disagrees with relay LED");

   // Input is ready whenever no result is waiting
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

endmodule

bind bistable_relay_pulse_controller brpc_check u_brpc_check (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: test/tb_bistable_relay_pulse_controller.sv
// Self-checking testbench for the bistable relay pulse controller.
// Depends on brpc_pkg and the top level bistable_relay_pulse_controller.
// A class-based predictor tracks relay, coil and timer state per tick word.
`timescale 1ns / 1ps

module tb_bistable_relay_pulse_controller;
   import brpc_pkg::*;

   localparam int TICKS_PER_TENTH   = 10;
   localparam int TENTHS_PER_SECOND = 10;
   localparam int PHASES            = 11;
   localparam int PHASE_TICKS       = 112;
   localparam int DIRECTED_TICKS    = 24;

   // Predicts the drive word of every tick and checks the words that come back
   class relay_drive_scoreboard;
      cfg_type      cfg;
      logic         relay_now;
      request_type  pending;
      bit           started;
      logic         prev_raw;
      bit           deb_busy;
      logic [7:0]   deb_left;
      logic [7:0]   pause_left;
      logic [7:0]   pulse_left;
      logic [7:0]   on_left;
      accepted_type last_active;
      int unsigned  tick_div;
      int unsigned  tenth_div;
      coil_type     coil;
      logic         info_on;
      logic [3:0]   drive_words_q[$];
      string        field_name[4];
      int unsigned  errors;
      int unsigned  ticks;
      int unsigned  words;
      int unsigned  switches;

      function new();
         cfg.toggle_mode      = 1'b0;
         cfg.active_high      = 1'b1;
         cfg.reset_at_startup = 1'b0;
         cfg.pause_tenths     = PAUSE_TENTHS_RESET;
         cfg.pulse_tenths     = PULSE_TENTHS_RESET;
         cfg.on_seconds       = 8'd0;
         cfg.debounce_enable  = 1'b1;
         cfg.debounce_ticks   = DEBOUNCE_TICKS_RESET;
         relay_now   = 1'b0;
         pending     = REQ_NONE;
         started     = 1'b0;
         prev_raw    = 1'b0;
         deb_busy    = 1'b0;
         deb_left    = '0;
         pause_left  = '0;
         pulse_left  = '0;
         on_left     = '0;
         last_active = ACC_UNKNOWN;
         tick_div    = 0;
         tenth_div   = 0;
         coil        = COIL_OFF;
         info_on     = 1'b0;
         errors      = 0;
         ticks       = 0;
         words       = 0;
         switches    = 0;
         field_name[RSP_COIL_RESET] = "coil_reset_drive";
         field_name[RSP_COIL_SET]   = "coil_set_drive";
         field_name[RSP_RELAY_LED]  = "relay_led";
         field_name[RSP_INFO_LED]   = "info_led";
      endfunction

      function void set_reg(csr_index_type idx, logic [7:0] v);
         case (idx)
            CSR_TOGGLE_MODE:      cfg.toggle_mode      = v[0];
            CSR_ACTIVE_HIGH:      cfg.active_high      = v[0];
            CSR_RESET_AT_STARTUP: cfg.reset_at_startup = v[0];
            CSR_PAUSE_TENTHS:     cfg.pause_tenths     = v;
            CSR_PULSE_TENTHS:     cfg.pulse_tenths     = v;
            CSR_ON_SECONDS:       cfg.on_seconds       = v;
            CSR_DEBOUNCE_ENABLE:  cfg.debounce_enable  = v[0];
            CSR_DEBOUNCE_TICKS:   cfg.debounce_ticks   = v;
            default: ;
         endcase
      endfunction

      // Fire one coil, restart pause and pulse timers, arm the on-time when setting
      function void do_switch(logic set_it);
         relay_now = set_it;
         coil      = set_it ? COIL_SET : COIL_RESET;
         info_on   = 1'b1;
         if (set_it)
            on_left = cfg.on_seconds;
         pulse_left = cfg.pulse_tenths;
         pause_left = cfg.pause_tenths;
         tick_div   = 0;
         pending    = REQ_NONE;
         switches++;
      endfunction

      function void accept_switch(logic active);
         if (cfg.toggle_mode)
            do_switch(!relay_now);
         else
            do_switch(active);
      endfunction

      // Recheck the level after the debounce wait; drop the request if unchanged
      function void finish_debounce(logic active);
         accepted_type level_now;
         level_now = active ? ACC_HIGH : ACC_LOW;
         deb_busy  = 1'b0;
         if (last_active == level_now) begin
            pending = REQ_NONE;
            return;
         end
         last_active = level_now;
         accept_switch(active);
      endfunction

      // 100 ms timer: on-time per second, then pause, then pulse
      function void tenth_event(logic active);
         tenth_div++;
         if (tenth_div >= TENTHS_PER_SECOND) begin
            tenth_div = 0;
            if (on_left != 0) begin
               on_left--;
               if (on_left == 0)
                  pending = REQ_RESET;
            end
         end
         if (pause_left != 0) begin
            pause_left--;
            if (pause_left == 0 && !cfg.toggle_mode && active != relay_now && pulse_left == 0)
               pending = REQ_SWITCH;
         end
         if (pulse_left != 0) begin
            pulse_left--;
            if (pulse_left == 0) begin
               coil    = COIL_OFF;
               info_on = 1'b0;
            end
         end
      endfunction

      // Advance the predicted controller by one tick word and queue its drive word
      function void note_tick(logic raw);
         logic       active;
         logic [3:0] w;
         active = (raw == cfg.active_high);
         ticks++;
         if (!started) begin
            started = 1'b1;
            if (cfg.toggle_mode) begin
               if (cfg.reset_at_startup)
                  pending = REQ_RESET;
            end else if (active) begin
               pending = REQ_SWITCH;
            end else if (cfg.reset_at_startup) begin
               pending = REQ_RESET;
            end
         end else if (raw != prev_raw && pause_left == 0) begin
            pending = REQ_SWITCH;
         end
         prev_raw = raw;

         tick_div++;
         if (tick_div >= TICKS_PER_TENTH) begin
            tick_div = 0;
            tenth_event(active);
         end

         if (deb_busy) begin
            if (deb_left != 0)
               deb_left--;
            if (deb_left == 0)
               finish_debounce(active);
         end else if (pending == REQ_RESET) begin
            do_switch(1'b0);
         end else if (pending == REQ_SWITCH) begin
            if (cfg.debounce_enable) begin
               deb_busy = 1'b1;
               deb_left = cfg.debounce_ticks;
               if (deb_left == 0)
                  finish_debounce(active);
            end else begin
               accept_switch(active);
            end
         end

         w = '0;
         w[RSP_COIL_RESET] = (coil == COIL_RESET);
         w[RSP_COIL_SET]   = (coil == COIL_SET);
         w[RSP_RELAY_LED]  = relay_now;
         w[RSP_INFO_LED]   = info_on;
         drive_words_q.push_back(w);
      endfunction

      // Compare a drive word field by field with the oldest prediction
      function void check_drive(logic [7:0] data);
         logic [3:0] w;
         if (drive_words_q.size() == 0) begin
            errors++;
            $display("%0t ns: drive word with no tick pending, expected none, actual %b",
                     $time, data[3:0]);
            return;
         end
         w = drive_words_q.pop_front();
         words++;
         for (int i = 0; i < 4; i++) begin
            if (data[i] !== w[i]) begin
               errors++;
               $display("%0t ns: %s expected %0b, actual %0b",
                        $time, field_name[i], w[i], data[i]);
            end
         end
      endfunction

      function int unsigned outstanding();
         return drive_words_q.size();
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;   // [0] raw_level, rest zero
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [0] coil_reset_drive, [1] coil_set_drive,
                                    // [2] relay_led, [3] info_led
   logic                       csr_we    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   bit gaps_on = 1'b1;
   relay_drive_scoreboard drive_sb = new();

   bistable_relay_pulse_controller i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Take drive words, then pick the next ready with random stalls while gaps are on
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         drive_sb.check_drive(rsp_tdata);
      rsp_tready <= !gaps_on || ($urandom_range(0, 99) >= 32);
   end

   // Offer one tick word, idling at random while gaps are on, and hold until it is taken
   task automatic drive_tick(input logic raw);
      while (gaps_on && $urandom_range(0, 99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, raw};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      drive_sb.note_tick(raw);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [7:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      drive_sb.set_reg(idx, v);
   endtask

   task automatic write_config(input cfg_type c);
      put_reg(CSR_TOGGLE_MODE,      {7'd0, c.toggle_mode});
      put_reg(CSR_ACTIVE_HIGH,      {7'd0, c.active_high});
      put_reg(CSR_RESET_AT_STARTUP, {7'd0, c.reset_at_startup});
      put_reg(CSR_PAUSE_TENTHS,     c.pause_tenths);
      put_reg(CSR_PULSE_TENTHS,     c.pulse_tenths);
      put_reg(CSR_ON_SECONDS,       c.on_seconds);
      put_reg(CSR_DEBOUNCE_ENABLE,  {7'd0, c.debounce_enable});
      put_reg(CSR_DEBOUNCE_TICKS,   c.debounce_ticks);
      csr_we <= 1'b0;
   endtask

   // Drop valid and drain every predicted word before touching the registers
   task automatic settle();
      req_tvalid <= 1'b0;
      while (drive_sb.outstanding() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Level runs of random length with occasional one-tick glitches
   task automatic play_levels(input int unsigned count);
      logic        level;
      int unsigned run;
      int unsigned sent;
      level = 1'($urandom_range(0, 1));
      sent  = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 15) begin
            drive_tick(!level);
            sent++;
         end else begin
            level = !level;
            run   = $urandom_range(1, 40);
            repeat (run) begin
               if (sent < count) begin
                  drive_tick(level);
                  sent++;
               end
            end
         end
      end
   endtask

   // Mostly small counts, now and then the top value
   function automatic logic [7:0] pick_count(input int unsigned hi);
      if ($urandom_range(0, 11) == 0)
         return 8'd255;
      return 8'($urandom_range(0, hi));
   endfunction

   // First phase all minimum, last all maximum (long pause would block the rest)
   function automatic cfg_type phase_config(input int p);
      cfg_type c;
      if (p == 0) begin
         c = '0;
      end else if (p == PHASES - 1) begin
         c = '1;
      end else begin
         c.toggle_mode      = 1'($urandom_range(0, 1));
         c.active_high      = 1'($urandom_range(0, 1));
         c.reset_at_startup = 1'($urandom_range(0, 1));
         c.pause_tenths     = 8'($urandom_range(0, 4));
         c.pulse_tenths     = pick_count(4);
         c.on_seconds       = 8'($urandom_range(0, 2));
         c.debounce_enable  = ($urandom_range(0, 3) != 0);
         c.debounce_ticks   = pick_count(20);
      end
      return c;
   endfunction

   initial begin
      cfg_type c;
      logic    directed_levels [DIRECTED_TICKS];
      // Startup reset while inactive, edges swallowed by the pause, recheck at
      // pause end with zero debounce, then edges and glitches after it
      directed_levels = '{0, 1, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                          1, 1, 0, 1, 0, 0, 0, 1, 1, 0, 1, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      c.toggle_mode      = 1'b0;
      c.active_high      = 1'b1;
      c.reset_at_startup = 1'b1;
      c.pause_tenths     = 8'd1;
      c.pulse_tenths     = 8'd1;
      c.on_seconds       = 8'd1;
      c.debounce_enable  = 1'b1;
      c.debounce_ticks   = 8'd0;
      write_config(c);
      for (int i = 0; i < DIRECTED_TICKS; i++)
         drive_tick(directed_levels[i]);
      settle();

      // Phases, random apart from the first and last; one runs with no idling on either side
      for (int p = 0; p < PHASES; p++) begin
         write_config(phase_config(p));
         gaps_on = (p != 5);
         play_levels(PHASE_TICKS);
         settle();
      end

      $display("Drove %0d tick words under %0d register settings, checked %0d drive words",
               drive_sb.ticks, PHASES + 1, drive_sb.words);
      $display("Predicted %0d coil pulses across direct, toggle, debounce and timer paths",
               drive_sb.switches);
      if (drive_sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog against a hung handshake
   initial begin
      #5_000_000;
      $display("Timeout waiting for the controller");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
